FILE: rtl/nsp_pkg.sv
// shared constants and types for the nearest seed pixel colour unit
package nsp_pkg;

  localparam int MAX_SEEDS = 64;
  localparam int ADDR_W    = $clog2(MAX_SEEDS);
  localparam int SLOT_W    = 6;
  localparam int COORD_W   = 16;
  localparam int PIX_W     = 12;
  localparam int RGBA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W - 1;
  localparam int DIST_W    = SQ_W + 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic                REG_SEED_COUNT = 1'b0;
  localparam logic [CNT_W-1:0]    SEED_COUNT_RST = CNT_W'(1);

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RGBA_W-1:0]         rgba;
  } seed_t;

  typedef struct packed {
    logic              last;
    logic [ADDR_W-1:0] slot;
    logic [RGBA_W-1:0] rgba;
  } tag_t;

endpackage

FILE: rtl/nearest_seed_pixel_color_unit.sv
// nearest seed pixel colour unit: seed table, scan sequencer and result register
// a seed load is written to the table on acceptance and leaves the unit ready at once
// a pixel query scans the first seed_count slots of the table, seed_count
// clamped to 1..64; the scan reads one seed a cycle through the distance pipeline
// no request is taken until the result is in the output register, so a new query
// waits for the last one; reset sets seed_count to 1, the seed table is not cleared
module nearest_seed_pixel_color_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [nsp_pkg::SLOT_W-1:0]        in_seed_slot,
  input  logic signed [nsp_pkg::COORD_W-1:0] in_seed_x,
  input  logic signed [nsp_pkg::COORD_W-1:0] in_seed_y,
  input  logic [nsp_pkg::RGBA_W-1:0]        in_seed_rgba,
  input  logic [nsp_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [nsp_pkg::PIX_W-1:0]         in_pixel_y,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nsp_pkg::RGBA_W-1:0]        out_pixel_rgba,
  output logic [nsp_pkg::SLOT_W-1:0]        out_nearest_slot,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsp_pkg::PADDR_W-1:0]       paddr,
  input  logic [nsp_pkg::PDATA_W-1:0]       pwdata,
  output logic [nsp_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                        state_r;
  logic [nsp_pkg::CNT_W-1:0]     seed_count_r;
  logic [nsp_pkg::ADDR_W-1:0]    addr_r, last_r, last_nxt;
  logic [nsp_pkg::PIX_W-1:0]     px_r, py_r;
  nsp_pkg::seed_t                mem [nsp_pkg::MAX_SEEDS];
  nsp_pkg::seed_t                rd_entry_r;
  logic                          rd_valid_r;
  logic [nsp_pkg::ADDR_W-1:0]    rd_slot_r;
  logic                          rd_last_r;
  nsp_pkg::tag_t                 rd_tag;
  logic                          d_valid;
  logic [nsp_pkg::DIST_W-1:0]    d_dist;
  nsp_pkg::tag_t                 d_tag;
  logic [nsp_pkg::DIST_W-1:0]    best_d_r;
  logic [nsp_pkg::ADDR_W-1:0]    best_slot_r;
  logic [nsp_pkg::RGBA_W-1:0]    best_rgba_r;
  logic                          out_valid_r;
  logic [nsp_pkg::RGBA_W-1:0]    out_rgba_r;
  logic [nsp_pkg::SLOT_W-1:0]    out_slot_r;
  logic                          take, take_load, take_query, cfg_wr, issue;

  assign in_ready   = (state_r == ST_IDLE);
  assign take       = in_valid && in_ready;
  assign take_load  = take && (in_kind == nsp_pkg::KIND_LOAD);
  assign take_query = take && (in_kind == nsp_pkg::KIND_QUERY);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign issue      = (state_r == ST_SCAN);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nsp_pkg::REG_SEED_COUNT) ?
                  nsp_pkg::PDATA_W'(seed_count_r) : '0;

  // zero count acts as one, large counts saturate at the table depth
  always_comb begin
    if (seed_count_r == '0) begin
      last_nxt = '0;
    end else if (seed_count_r > nsp_pkg::CNT_W'(nsp_pkg::MAX_SEEDS)) begin
      last_nxt = nsp_pkg::ADDR_W'(nsp_pkg::MAX_SEEDS - 1);
    end else begin
      last_nxt = nsp_pkg::ADDR_W'(seed_count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r <= nsp_pkg::SEED_COUNT_RST;
    end else if (cfg_wr && paddr[2] == nsp_pkg::REG_SEED_COUNT) begin
      seed_count_r <= pwdata[nsp_pkg::CNT_W-1:0];
    end
  end

  // seed table
  always_ff @(posedge clk) begin
    if (take_load && 32'(in_seed_slot) < 32'(nsp_pkg::MAX_SEEDS)) begin
      mem[in_seed_slot[nsp_pkg::ADDR_W-1:0]] <= '{x: in_seed_x, y: in_seed_y,
                                                  rgba: in_seed_rgba};
    end
    if (issue) begin
      rd_entry_r <= mem[addr_r];
    end
    rd_slot_r <= addr_r;
    rd_last_r <= (addr_r == last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
    end
  end

  assign rd_tag = '{last: rd_last_r, slot: rd_slot_r, rgba: rd_entry_r.rgba};

  nsp_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_valid_r),
    .seed_x    (rd_entry_r.x),
    .seed_y    (rd_entry_r.y),
    .pix_x     (px_r),
    .pix_y     (py_r),
    .in_tag    (rd_tag),
    .out_valid (d_valid),
    .out_dist  (d_dist),
    .out_tag   (d_tag)
  );

  // running minimum, strictly less keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (d_valid && (d_tag.slot == '0 || d_dist < best_d_r)) begin
      best_d_r    <= d_dist;
      best_slot_r <= d_tag.slot;
      best_rgba_r <= d_tag.rgba;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take_query) begin
            px_r    <= in_pixel_x;
            py_r    <= in_pixel_y;
            last_r  <= last_nxt;
            addr_r  <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr_r == last_r) begin
            state_r <= ST_DRAIN;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (d_valid && d_tag.last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_rgba_r  <= best_rgba_r;
            out_slot_r  <= nsp_pkg::SLOT_W'(best_slot_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_rgba   = out_rgba_r;
  assign out_nearest_slot = out_slot_r;

endmodule

FILE: rtl/nsp_dist.sv
// pipelined squared distance unit, one seed per cycle
module nsp_dist (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [nsp_pkg::COORD_W-1:0] seed_x,
  input  logic signed [nsp_pkg::COORD_W-1:0] seed_y,
  input  logic [nsp_pkg::PIX_W-1:0]         pix_x,
  input  logic [nsp_pkg::PIX_W-1:0]         pix_y,
  input  nsp_pkg::tag_t                     in_tag,
  output logic                              out_valid,
  output logic [nsp_pkg::DIST_W-1:0]        out_dist,
  output nsp_pkg::tag_t                     out_tag
);

  logic signed [nsp_pkg::DIFF_W-1:0]   dx_nxt, dy_nxt;
  logic signed [nsp_pkg::DIFF_W-1:0]   dx_r, dy_r;
  logic signed [2*nsp_pkg::DIFF_W-1:0] sqx_full, sqy_full;
  logic [nsp_pkg::SQ_W-1:0]            sqx_r, sqy_r;
  logic [nsp_pkg::DIST_W-1:0]          dist_r;
  logic                                v1_r, v2_r, v3_r;
  nsp_pkg::tag_t                       tag1_r, tag2_r, tag3_r;

  always_comb begin
    dx_nxt = signed'({seed_x[nsp_pkg::COORD_W-1], seed_x})
           - signed'({{(nsp_pkg::DIFF_W - nsp_pkg::PIX_W){1'b0}}, pix_x});
    dy_nxt = signed'({seed_y[nsp_pkg::COORD_W-1], seed_y})
           - signed'({{(nsp_pkg::DIFF_W - nsp_pkg::PIX_W){1'b0}}, pix_y});
    sqx_full = dx_r * dx_r;
    sqy_full = dy_r * dy_r;
  end

  // squares are never negative, so the low bits hold the whole value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    tag1_r <= in_tag;
    sqx_r  <= sqx_full[nsp_pkg::SQ_W-1:0];
    sqy_r  <= sqy_full[nsp_pkg::SQ_W-1:0];
    tag2_r <= tag1_r;
    dist_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
    tag3_r <= tag2_r;
  end

  assign out_valid = v3_r;
  assign out_dist  = dist_r;
  assign out_tag   = tag3_r;

endmodule

FILE: rtl/nsp_checker.sv
// port-level checks for the nearest seed pixel colour unit, bound to the top level
module nsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nsp_pkg::RGBA_W-1:0]   out_pixel_rgba,
  input logic [nsp_pkg::SLOT_W-1:0]   out_nearest_slot,
  input logic                         pready
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_rgba)
                                && $stable(out_nearest_slot))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

  // a query drops ready and keeps it low as the scan begins
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == nsp_pkg::KIND_QUERY |=> !in_ready ##1 !in_ready)
    else $error("ready during scan");

  // a seed load leaves the unit ready in the following cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == nsp_pkg::KIND_LOAD |=> in_ready)
    else $error("load stalled the unit");

endmodule

bind nearest_seed_pixel_color_unit nsp_checker u_nsp_checker (.*);

FILE: sim/nearest_seed_pixel_color_unit_test.sv
// testbench for the nearest seed pixel colour unit: seed loads, pixel requests, seed count
`timescale 1ns / 100ps

module nearest_seed_pixel_color_unit_test;
  import nsp_pkg::*;

  localparam logic [PADDR_W-1:0] SEED_COUNT_ADDR = PADDR_W'(4 * int'(REG_SEED_COUNT));
  localparam int DRAIN_CYCLES = MAX_SEEDS + 16;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    kind_t                     kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RGBA_W-1:0]         rgba;
    logic [PIX_W-1:0]          px;
    logic [PIX_W-1:0]          py;
  } request_t;

  typedef struct {
    logic [RGBA_W-1:0] rgba;
    logic [SLOT_W-1:0] slot;
  } colour_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_kind = KIND_LOAD;
  logic [SLOT_W-1:0]         in_seed_slot = '0;
  logic signed [COORD_W-1:0] in_seed_x = '0;
  logic signed [COORD_W-1:0] in_seed_y = '0;
  logic [RGBA_W-1:0]         in_seed_rgba = '0;
  logic [PIX_W-1:0]          in_pixel_x = '0;
  logic [PIX_W-1:0]          in_pixel_y = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [RGBA_W-1:0]         out_pixel_rgba;
  logic [SLOT_W-1:0]         out_nearest_slot;

  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  // our own copy of the seed table and the search length
  logic signed [COORD_W-1:0] seed_x_copy [MAX_SEEDS];
  logic signed [COORD_W-1:0] seed_y_copy [MAX_SEEDS];
  logic [RGBA_W-1:0]         seed_rgba_copy [MAX_SEEDS];
  logic [CNT_W-1:0]          seed_count_copy = SEED_COUNT_RST;

  colour_t pending_colours[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  nearest_seed_pixel_color_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_seed_slot     (in_seed_slot),
    .in_seed_x        (in_seed_x),
    .in_seed_y        (in_seed_y),
    .in_seed_rgba     (in_seed_rgba),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_rgba   (out_pixel_rgba),
    .out_nearest_slot (out_nearest_slot),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // nearest seed by exact squared distance, strictly-less so the lowest slot wins a tie
  function automatic colour_t nearest_colour(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    colour_t res;
    int n;
    int best;
    longint dx;
    longint dy;
    longint d;
    longint best_d;
    n = int'(seed_count_copy);
    if (n < 1) n = 1;
    if (n > MAX_SEEDS) n = MAX_SEEDS;
    best = 0;
    best_d = 0;
    for (int k = 0; k < n; k++) begin
      dx = longint'(seed_x_copy[k]) - longint'(px);
      dy = longint'(seed_y_copy[k]) - longint'(py);
      d = dx * dx + dy * dy;
      if (k == 0 || d < best_d) begin
        best_d = d;
        best = k;
      end
    end
    res.rgba = seed_rgba_copy[best];
    res.slot = SLOT_W'(best);
    return res;
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    colour_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_colours.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: rgba %h slot %0d",
                                  out_pixel_rgba, out_nearest_slot));
      end else begin
        want = pending_colours.pop_front();
        if (out_pixel_rgba !== want.rgba)
          report_mismatch($sformatf("pixel_rgba expected %h got %h", want.rgba,
                                    out_pixel_rgba));
        if (out_nearest_slot !== want.slot)
          report_mismatch($sformatf("nearest_slot expected %0d got %0d", want.slot,
                                    out_nearest_slot));
      end
    end
  end

  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= r.kind;
    in_seed_slot <= r.slot;
    in_seed_x    <= r.x;
    in_seed_y    <= r.y;
    in_seed_rgba <= r.rgba;
    in_pixel_x   <= r.px;
    in_pixel_y   <= r.py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.kind == KIND_LOAD) begin
      seed_x_copy[r.slot]    = r.x;
      seed_y_copy[r.slot]    = r.y;
      seed_rgba_copy[r.slot] = r.rgba;
    end else begin
      pending_colours.push_back(nearest_colour(r.px, r.py));
    end
  endtask

  task automatic load_seed(logic [SLOT_W-1:0] slot, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y, logic [RGBA_W-1:0] rgba);
    request_t r;
    r.kind = KIND_LOAD;
    r.slot = slot;
    r.x = x;
    r.y = y;
    r.rgba = rgba;
    r.px = PIX_W'($urandom);
    r.py = PIX_W'($urandom);
    send_request(r);
  endtask

  task automatic query_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    request_t r;
    r.kind = KIND_QUERY;
    r.slot = SLOT_W'($urandom);
    r.x = COORD_W'($urandom);
    r.y = COORD_W'($urandom);
    r.rgba = $urandom;
    r.px = px;
    r.py = py;
    send_request(r);
  endtask

  // loads never stall the unit, so a short settle after the last result is enough
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed_count(logic [PDATA_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_COUNT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_count_copy = value[CNT_W-1:0];
  endtask

  function automatic request_t random_request();
    request_t r;
    int src;
    r.kind = ($urandom_range(99) < 35) ? KIND_LOAD : KIND_QUERY;
    r.slot = SLOT_W'($urandom);
    r.rgba = $urandom;
    r.px = PIX_W'($urandom);
    r.py = PIX_W'($urandom);
    case ($urandom_range(9))
      0, 1, 2: begin
        r.x = COORD_W'($urandom);
        r.y = COORD_W'($urandom);
      end
      3, 4: begin
        // same position as another seed, so ties come up often
        src = $urandom_range(MAX_SEEDS - 1);
        r.x = seed_x_copy[src];
        r.y = seed_y_copy[src];
      end
      default: begin
        r.x = COORD_W'(int'($urandom_range(4223)) - 64);
        r.y = COORD_W'(int'($urandom_range(4223)) - 64);
      end
    endcase
    if ($urandom_range(9) == 0) begin
      r.px = $urandom_range(1) ? '1 : '0;
      r.py = $urandom_range(1) ? '1 : '0;
    end
    return r;
  endfunction

  // reset search length is one, so only slot 0 counts
  task automatic test_single_seed();
    load_seed(6'd0, -16'sd32768, 16'sd32767, 32'hFFFF_FFFF);
    query_pixel(12'd0, 12'd0);
    query_pixel(12'hFFF, 12'hFFF);
    load_seed(6'd0, 16'sd32767, -16'sd32768, 32'h0000_0000);
    query_pixel(12'hFFF, 12'd0);
    query_pixel(12'd0, 12'hFFF);
  endtask

  task automatic test_full_table();
    for (int k = 0; k < MAX_SEEDS; k++)
      load_seed(SLOT_W'(k), COORD_W'($urandom_range(4095)), COORD_W'($urandom_range(4095)),
                $urandom);
    load_seed(SLOT_W'(MAX_SEEDS - 1), 16'sd32767, -16'sd32768, 32'hA5A5_5A5A);
    query_pixel(12'd2048, 12'd2048);
    write_seed_count(MAX_SEEDS);
    query_pixel(12'd0, 12'd0);
    query_pixel(12'hFFF, 12'd0);
    query_pixel(12'd0, 12'hFFF);
    query_pixel(12'hFFF, 12'hFFF);
  endtask

  // zero acts as one, anything past the table saturates, upper data bits are ignored
  task automatic test_count_limits();
    write_seed_count(0);
    query_pixel(12'd100, 12'd3000);
    write_seed_count(127);
    query_pixel(12'd3000, 12'd100);
    write_seed_count(MAX_SEEDS + 1);
    query_pixel(12'd1234, 12'd2345);
    write_seed_count(32'hFFFF_FFC0);
    query_pixel(12'd4000, 12'd17);
  endtask

  task automatic test_ties();
    load_seed(6'd5, 16'sd1000, 16'sd1000, 32'h1111_1111);
    load_seed(6'd9, 16'sd1000, 16'sd1000, 32'h2222_2222);
    load_seed(6'd12, 16'sd2000, 16'sd2000, 32'h3333_3333);
    load_seed(6'd13, 16'sd2002, 16'sd2000, 32'h4444_4444);
    query_pixel(12'd1000, 12'd1000);
    query_pixel(12'd1000, 12'd1001);
    query_pixel(12'd2001, 12'd2000);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int num_items);
    int done;
    logic [CNT_W-1:0] cnt;
    logic [PDATA_W-1:0] wval;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < num_items) begin
      case ($urandom_range(7))
        0: cnt = CNT_W'(1);
        1: cnt = CNT_W'(MAX_SEEDS);
        2: cnt = '0;
        3: cnt = '1;
        default: cnt = CNT_W'($urandom);
      endcase
      wval = $urandom;
      if ($urandom_range(3) != 0) wval = '0;
      wval[CNT_W-1:0] = cnt;
      write_seed_count(wval);
      repeat ($urandom_range(140, 60)) begin
        send_request(random_request());
        done++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 7;
    recv_idle_pct = 47;
    test_single_seed();
    test_full_table();
    test_count_limits();
    test_ties();
    test_random_traffic(7, 47, 670);
    test_random_traffic(47, 7, 670);
    test_random_traffic(0, 0, 670);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_colours.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
